// ----- src/dibrgba_pkg.sv -----
// Shared types, constants and helper functions for the DIB pixel to RGBA converter.
package dibrgba_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int PAL_W       = 24;
    localparam int IDX_W       = 8;
    localparam logic [IDX_W:0] PAL_LIMIT = (IDX_W + 1)'(PAL_ENTRIES);

    localparam int BPP_W = 6;
    localparam logic [BPP_W-1:0] BPP_RESET = 6'd32;
    localparam logic [BPP_W-1:0] BPP_1     = 6'd1;
    localparam logic [BPP_W-1:0] BPP_4     = 6'd4;
    localparam logic [BPP_W-1:0] BPP_8     = 6'd8;
    localparam logic [BPP_W-1:0] BPP_16    = 6'd16;
    localparam logic [BPP_W-1:0] BPP_24    = 6'd24;
    localparam logic [BPP_W-1:0] BPP_32    = 6'd32;

    localparam int APB_AW = 3;
    localparam logic [APB_AW-1:0] ADDR_BPP = 3'd0;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  entry_index;
        logic [23:0] entry_color;
        logic [31:0] pixel_raw;
        logic        mask_bit;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef enum logic [4:0] {
        MODE_NONE    = 5'b00001,
        MODE_BGRA32  = 5'b00010,
        MODE_BGR24   = 5'b00100,
        MODE_RGB555  = 5'b01000,
        MODE_INDEXED = 5'b10000
    } mode_t;

    function automatic mode_t decode_mode(input logic [BPP_W-1:0] bpp);
        mode_t m;
        case (bpp)
            BPP_32:  m = MODE_BGRA32;
            BPP_24:  m = MODE_BGR24;
            BPP_16:  m = MODE_RGB555;
            BPP_8:   m = MODE_INDEXED;
            BPP_4:   m = MODE_INDEXED;
            BPP_1:   m = MODE_INDEXED;
            default: m = MODE_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [IDX_W-1:0] pal_index(input logic [BPP_W-1:0] bpp,
                                                   input logic [31:0] px);
        logic [IDX_W-1:0] idx;
        case (bpp)
            BPP_1:   idx = {7'b0, px[0]};
            BPP_4:   idx = {4'b0, px[3:0]};
            default: idx = px[7:0];
        endcase
        return idx;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

// ----- src/dibrgba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dibrgba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/dib_pixel_to_rgba_top.sv -----
// Top level of the DIB pixel to RGBA converter: palette, pipeline and register port.
//
// Input channel s_valid/s_ready/s_data carries items: a load item (opcode 0)
// writes one palette entry and gives no result; a convert item (opcode 1)
// gives one RGBA result on m_valid/m_ready/m_data.
// The APB port holds bits_per_pixel at address 0; write it only while idle.
// Pipeline: palette read and index decode, mode select, output register.
// m_valid rises once a convert item has passed the s1, s2 and output registers; one item
// per cycle is sustained without stalls, as the palette has its own read and write ports.
// A load is visible to a convert item accepted in the very next cycle.
// Reset (aresetn low, synchronous) empties the pipeline, sets
// bits_per_pixel to 32 and marks every palette entry as zero through
// per-entry valid bits, so no clearing pass is needed.
// When the receiver stalls, results stay in the stages and s_ready falls
// only once every stage holds an item; nothing is lost or repeated.
module dib_pixel_to_rgba_top
    import dibrgba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pix_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rgba_t             m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [BPP_W-1:0]       bpp_reg, bpp_next;
    logic [PAL_ENTRIES-1:0] pal_valid_reg, pal_valid_next;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    logic en1, en2, en_out, s_accept;

    logic [IDX_W-1:0]  rd_idx;
    logic [PAL_AW-1:0] rd_addr, wr_addr;
    logic              rd_in_range, wr_in_range, pal_we;
    logic [PAL_W-1:0]  pal_rdata;

    logic [31:0] s1_px_reg;
    logic        s1_mask_reg;
    logic        s1_hit_reg;

    mode_t       s2_mode_reg;
    logic [31:0] s2_px_reg;
    logic [23:0] s2_pal_reg;
    logic [7:0]  s2_alpha_reg;

    rgba_t out_reg, out_next;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BPP) ? {{(32 - BPP_W){1'b0}}, bpp_reg} : 32'd0;

    always_comb begin
        bpp_next = bpp_reg;
        if (psel && penable && pwrite && (paddr == ADDR_BPP)) begin
            bpp_next = pwdata[BPP_W-1:0];
        end
    end

    // Handshake chain
    assign en_out   = !out_valid_reg || m_ready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign s_ready  = en1;
    assign s_accept = s_valid && en1;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Palette
    assign rd_idx      = pal_index(bpp_reg, s_data.pixel_raw);
    assign rd_in_range = {1'b0, rd_idx} < PAL_LIMIT;
    assign rd_addr     = rd_idx[PAL_AW-1:0];
    assign wr_in_range = {1'b0, s_data.entry_index} < PAL_LIMIT;
    assign wr_addr     = s_data.entry_index[PAL_AW-1:0];
    assign pal_we      = s_accept && (s_data.opcode == OP_LOAD) && wr_in_range;

    dibrgba_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (wr_addr),
        .wdata (s_data.entry_color),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (pal_rdata)
    );

    always_comb begin
        pal_valid_next = pal_valid_reg;
        if (pal_we) begin
            pal_valid_next[wr_addr] = 1'b1;
        end
    end

    // Valid bits
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (en1) begin
            s1_valid_next = s_valid && (s_data.opcode == OP_CONVERT);
        end
        if (en2) begin
            s2_valid_next = s1_valid_reg;
        end
        if (en_out) begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= BPP_RESET;
            pal_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            bpp_reg       <= bpp_next;
            pal_valid_reg <= pal_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output stage mux
    always_comb begin
        out_next = '0;
        case (s2_mode_reg)
            MODE_BGRA32: begin
                out_next.red   = s2_px_reg[23:16];
                out_next.green = s2_px_reg[15:8];
                out_next.blue  = s2_px_reg[7:0];
                out_next.alpha = s2_px_reg[31:24];
            end
            MODE_BGR24: begin
                out_next.red   = s2_px_reg[23:16];
                out_next.green = s2_px_reg[15:8];
                out_next.blue  = s2_px_reg[7:0];
                out_next.alpha = s2_alpha_reg;
            end
            MODE_RGB555: begin
                out_next.red   = widen5(s2_px_reg[14:10]);
                out_next.green = widen5(s2_px_reg[9:5]);
                out_next.blue  = widen5(s2_px_reg[4:0]);
                out_next.alpha = s2_alpha_reg;
            end
            MODE_INDEXED: begin
                out_next.red   = s2_pal_reg[23:16];
                out_next.green = s2_pal_reg[15:8];
                out_next.blue  = s2_pal_reg[7:0];
                out_next.alpha = s2_alpha_reg;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_px_reg   <= s_data.pixel_raw;
            s1_mask_reg <= s_data.mask_bit;
            s1_hit_reg  <= rd_in_range && pal_valid_reg[rd_addr];
        end
        if (en2) begin
            s2_mode_reg  <= decode_mode(bpp_reg);
            s2_px_reg    <= s1_px_reg;
            s2_pal_reg   <= s1_hit_reg ? pal_rdata : 24'd0;
            s2_alpha_reg <= s1_mask_reg ? 8'd0 : ALPHA_OPAQUE;
        end
        if (en_out) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- verif/dib_pixel_to_rgba_checker.sv -----
// Checker for the DIB pixel to RGBA converter: mirrors palette and depth, predicts and compares.
module dib_pixel_to_rgba_checker
    import dibrgba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pix_in_t           s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rgba_t             m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PAL_W-1:0] palette_mirror [PAL_ENTRIES];
    logic [BPP_W-1:0] cur_depth;
    rgba_t            expected_px [$];
    rgba_t            oldest;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0] w;
        w = {3'b000, v} << 3;
        return w | 8'(v >> 2);
    endfunction

    function automatic rgba_t convert_pixel(input logic [31:0] px, input logic mask);
        rgba_t            px_out;
        logic [7:0]       mask_alpha;
        logic [31:0]      idx;
        logic [PAL_W-1:0] colour;
        px_out     = '0;
        mask_alpha = mask ? 8'h00 : ALPHA_OPAQUE;
        case (cur_depth)
            BPP_32: begin
                px_out.red   = px[23:16];
                px_out.green = px[15:8];
                px_out.blue  = px[7:0];
                px_out.alpha = px[31:24];
            end
            BPP_24: begin
                px_out.red   = px[23:16];
                px_out.green = px[15:8];
                px_out.blue  = px[7:0];
                px_out.alpha = mask_alpha;
            end
            BPP_16: begin
                px_out.red   = expand5(px[14:10]);
                px_out.green = expand5(px[9:5]);
                px_out.blue  = expand5(px[4:0]);
                px_out.alpha = mask_alpha;
            end
            BPP_8, BPP_4, BPP_1: begin
                idx    = px & ((32'd1 << cur_depth) - 32'd1);
                colour = (idx < PAL_ENTRIES) ? palette_mirror[idx[PAL_AW-1:0]] : '0;
                px_out.red   = colour[23:16];
                px_out.green = colour[15:8];
                px_out.blue  = colour[7:0];
                px_out.alpha = mask_alpha;
            end
            default: ;
        endcase
        return px_out;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_depth = BPP_RESET;
            for (int i = 0; i < PAL_ENTRIES; i++) palette_mirror[i] = '0;
            expected_px.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: r=%02h g=%02h b=%02h a=%02h",
                                 m_data.red, m_data.green, m_data.blue, m_data.alpha);
                end else begin
                    oldest = expected_px.pop_front();
                    if (oldest.red !== m_data.red || oldest.green !== m_data.green ||
                        oldest.blue !== m_data.blue || oldest.alpha !== m_data.alpha) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp r=%02h g=%02h b=%02h a=%02h, got r=%02h g=%02h b=%02h a=%02h",
                                     oldest.red, oldest.green, oldest.blue, oldest.alpha,
                                     m_data.red, m_data.green, m_data.blue, m_data.alpha);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_LOAD) begin
                    if (s_data.entry_index < PAL_ENTRIES)
                        palette_mirror[s_data.entry_index] = s_data.entry_color;
                end else begin
                    expected_px.push_back(convert_pixel(s_data.pixel_raw, s_data.mask_bit));
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_BPP)
                cur_depth = pwdata[BPP_W-1:0];
        end
        pending = expected_px.size();
    end

endmodule

// ----- verif/tb_dib_pixel_to_rgba_top.sv -----
// Testbench top for the DIB pixel to RGBA converter: clock, reset, stimulus and verdict.
module tb_dib_pixel_to_rgba_top;
    import dibrgba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 500000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pix_in_t           s_data;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rgba_t             m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    logic s_took = 1'b0;
    logic steady = 1'b0;
    int   errors;
    int   pending;
    int   cycle_count = 0;
    int   stall_left = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    dib_pixel_to_rgba_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dib_pixel_to_rgba_checker u_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    always @(posedge aclk) s_took <= s_valid && s_ready;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if (!steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
        end
    end

    task automatic send_item(input pix_in_t item);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic convert(input logic [31:0] px, input logic mask);
        pix_in_t item;
        item.opcode      = OP_CONVERT;
        item.entry_index = 8'($urandom);
        item.entry_color = 24'($urandom);
        item.pixel_raw   = px;
        item.mask_bit    = mask;
        send_item(item);
    endtask

    task automatic load(input logic [7:0] idx, input logic [23:0] colour);
        pix_in_t item;
        item.opcode      = OP_LOAD;
        item.entry_index = idx;
        item.entry_color = colour;
        item.pixel_raw   = $urandom;
        item.mask_bit    = 1'($urandom);
        send_item(item);
    endtask

    // a load leaves nothing to wait for, so the task waits on past the last result before writing
    task automatic set_depth(input logic [BPP_W-1:0] depth);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BPP;
        pwdata  = ($urandom & ~32'h3F) | 32'(depth);
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1) == 0) load(8'($urandom_range(0, 15)), 24'($urandom));
                else load(8'($urandom), 24'($urandom));
            end else begin
                convert($urandom, 1'($urandom));
            end
        end
    endtask

    initial begin
        logic [BPP_W-1:0] depth_plan [14];
        depth_plan = '{BPP_8, BPP_16, BPP_1, BPP_24, BPP_4, BPP_32, 6'd63,
                       BPP_8, 6'd0, BPP_4, BPP_24, BPP_1, BPP_16, 6'($urandom)};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // reset depth is 32 bpp
        convert(32'h0000_0000, 1'b0);
        convert(32'hFFFF_FFFF, 1'b1);
        convert(32'h80FF_0001, 1'b0);
        load(8'd0,   24'hFFFFFF);
        load(8'd255, 24'hABCDEF);
        load(8'd1,   24'h123456);
        load(8'd15,  24'h0F0F0F);

        set_depth(BPP_8);
        convert(32'hFFFF_FF00, 1'b0);
        convert(32'h0000_01FF, 1'b1);
        convert(32'h0000_0007, 1'b0);   // never loaded, reads as zero
        set_depth(BPP_4);
        convert(32'hFFFF_FFFF, 1'b0);
        convert(32'h0000_0010, 1'b1);
        set_depth(BPP_1);
        convert(32'hFFFF_FFFE, 1'b0);
        convert(32'h0000_0001, 1'b0);
        set_depth(BPP_16);
        convert(32'h0000_FFFF, 1'b0);
        convert(32'hFFFF_8000, 1'b0);
        convert(32'h0000_7C00, 1'b1);
        set_depth(BPP_24);
        convert(32'hFF00_0000, 1'b0);
        convert(32'h00FF_FFFF, 1'b1);
        set_depth(6'd0);
        convert(32'hFFFF_FFFF, 1'b0);
        set_depth(6'd63);
        convert(32'h1234_5678, 1'b0);

        for (int p = 0; p < 14; p++) begin
            set_depth(depth_plan[p]);
            steady = (p % 4 == 2);
            random_items(65);
        end
        steady  = 1'b0;
        s_valid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dibrgba_pkg.sv
src/dibrgba_ram.sv
src/dib_pixel_to_rgba_top.sv
verif/dib_pixel_to_rgba_checker.sv
verif/tb_dib_pixel_to_rgba_top.sv
